// ===== hw/rtl/terminal_escape_translator_macros.svh =====
// Assertion helpers for the escape translator checks.
`ifndef TERMINAL_ESCAPE_TRANSLATOR_MACROS_SVH
`define TERMINAL_ESCAPE_TRANSLATOR_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TET_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tet check failed");

// When pre holds, post must hold on the following clock edge.
`define TET_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tet check failed");

`endif

// ===== hw/rtl/tet_pkg.sv =====
package tet_pkg;

    // Byte codes seen or produced by the translator.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_AMP      = 8'h26;
    localparam logic [7:0] CH_PLUS     = 8'h2b;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_2        = 8'h32;
    localparam logic [7:0] CH_4        = 8'h34;
    localparam logic [7:0] CH_5        = 8'h35;
    localparam logic [7:0] CH_7        = 8'h37;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_B     = 8'h42;
    localparam logic [7:0] CH_UP_C     = 8'h43;
    localparam logic [7:0] CH_UP_D     = 8'h44;
    localparam logic [7:0] CH_UP_H     = 8'h48;
    localparam logic [7:0] CH_UP_J     = 8'h4a;
    localparam logic [7:0] CH_UP_K     = 8'h4b;
    localparam logic [7:0] CH_UP_L     = 8'h4c;
    localparam logic [7:0] CH_UP_Z     = 8'h5a;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_US       = 8'h5f;
    localparam logic [7:0] CH_LO_D     = 8'h64;
    localparam logic [7:0] CH_LO_F     = 8'h66;
    localparam logic [7:0] CH_LO_H     = 8'h68;
    localparam logic [7:0] CH_LO_L     = 8'h6c;
    localparam logic [7:0] CH_LO_M     = 8'h6d;
    localparam logic [7:0] CH_DEL      = 8'h7f;

    localparam int unsigned PARAM_W   = 15;
    localparam int unsigned SKIP_W    = 16;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 15'h7fff;

    typedef logic [PARAM_W-1:0] param_t;
    typedef logic [SKIP_W-1:0]  skip_t;

endpackage

// ===== hw/rtl/terminal_escape_translator.sv =====
// Latency: the first result of an input byte is offered on the cycle after its transfer.
// Throughput: one input byte per cycle while each byte yields at most one result and out_stall
//   is low; a byte with more results (up to 12) holds in_stall high until its last result leaves,
//   the sequencer draining them one per cycle unless out_stall; a byte with none holds nothing.
// Reset (rst_n low, asynchronous): parser returns to plain text with all counters cleared,
//   pending results are dropped and console_attached comes up as 1.
module terminal_escape_translator (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration: console_attached
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    // input byte channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_byte,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 delay_request,
    output logic                 last_of_run
);
    import tet_pkg::*;

    // Parser modes; unused codes fall back to plain text.
    typedef enum logic [2:0] {
        MODE_TEXT   = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_AMP    = 3'd2,
        MODE_AMPPAR = 3'd3,
        MODE_SKIP   = 3'd4,
        MODE_US     = 3'd5,
        MODE_USCR   = 3'd6
    } mode_t;

    // ---------------------------------------------------------------
    // Parser state
    // ---------------------------------------------------------------
    logic       console_reg;
    mode_t      mode_reg,   mode_next;
    logic [7:0] group_reg,  group_next;
    param_t     param_reg,  param_next;
    logic       neg_reg,    neg_next;
    param_t     label_reg,  label_next;
    param_t     string_reg, string_next;
    skip_t      skip_reg,   skip_next;

    // ---------------------------------------------------------------
    // Result sequencer: up to three literal bytes, then an optional
    // delay request or SGR attribute tail.
    // ---------------------------------------------------------------
    logic [7:0] buf0_reg, buf0_next;
    logic [7:0] buf1_reg, buf1_next;
    logic [7:0] buf2_reg, buf2_next;
    logic [1:0] cnt_reg,  cnt_next;
    logic       delay_reg, delay_next;
    logic       sgr_reg,   sgr_next;
    logic [3:0] mask_reg,  mask_next;
    logic       half_reg,  half_next;

    // Descriptor built from the incoming byte.
    logic [7:0] d_b0, d_b1, d_b2;
    logic [1:0] d_fill;
    logic       d_delay;
    logic       d_sgr;
    logic       run_text;
    logic       text_emit;

    logic       in_xfer;
    logic       out_xfer;
    logic       is_digit;
    logic       is_upper;
    logic       csi_hit;
    logic [7:0] csi_final;
    logic [18:0] param_mul;
    param_t     f_len;
    param_t     label_upd;
    param_t     string_upd;
    skip_t      skip_sum;
    logic [7:0] sgr_byte;

    assign is_digit = (in_byte >= CH_0) && (in_byte <= CH_9);
    assign is_upper = (in_byte >= CH_UP_A) && (in_byte <= CH_UP_Z);
    // Decimal accumulate; the low nibble of an ASCII digit is its value.
    assign param_mul = ({4'd0, param_reg} * 19'd10) + {15'd0, in_byte[3:0]};
    assign f_len     = neg_reg ? '0 : param_reg;

    assign label_upd  = ((in_byte == CH_LO_D) || (in_byte == CH_UP_D)) ? f_len : label_reg;
    assign string_upd = ((in_byte == CH_LO_L) || (in_byte == CH_UP_L)) ? f_len : string_reg;
    assign skip_sum   = {1'b0, label_upd} + {1'b0, string_upd};

    always_comb
    begin
        csi_hit   = 1'b1;
        csi_final = in_byte;
        unique case (in_byte)
            CH_UP_A, CH_UP_B, CH_UP_C, CH_UP_D, CH_UP_J, CH_UP_K: csi_final = in_byte;
            CH_UP_H, CH_LO_H:                                     csi_final = CH_UP_H;
            default:                                              csi_hit   = 1'b0;
        endcase
    end

    // Plain text byte: ESC and underscore open a sequence, NUL and DEL drop.
    assign text_emit = run_text && (in_byte != CH_ESC) && (in_byte != CH_US)
                       && (in_byte != CH_NUL) && (in_byte != CH_DEL);

    always_comb
    begin
        mode_next   = mode_reg;
        group_next  = group_reg;
        param_next  = param_reg;
        neg_next    = neg_reg;
        label_next  = label_reg;
        string_next = string_reg;
        skip_next   = skip_reg;
        d_b0        = CH_NUL;
        d_b1        = CH_NUL;
        d_b2        = CH_NUL;
        d_fill      = 2'd0;
        d_delay     = 1'b0;
        d_sgr       = 1'b0;
        run_text    = 1'b0;

        unique case (mode_reg)
            MODE_US:
            begin
                if (in_byte == CH_CR)
                begin
                    mode_next = MODE_USCR;
                end
                else if (in_byte == CH_US)
                begin
                    d_b0   = CH_US;
                    d_fill = 2'd1;
                end
                else
                begin
                    d_b0      = CH_US;
                    d_fill    = 2'd1;
                    mode_next = MODE_TEXT;
                    run_text  = 1'b1;
                end
            end
            MODE_USCR:
            begin
                mode_next = MODE_TEXT;
                if (in_byte != CH_LF)
                begin
                    d_b0     = CH_US;
                    d_b1     = CH_CR;
                    d_fill   = 2'd2;
                    run_text = 1'b1;
                end
            end
            MODE_ESC:
            begin
                if (in_byte == CH_AMP)
                begin
                    mode_next = MODE_AMP;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                    if (console_reg && csi_hit)
                    begin
                        d_b0   = CH_ESC;
                        d_b1   = CH_LBRACKET;
                        d_b2   = csi_final;
                        d_fill = 2'd3;
                    end
                    else if (console_reg && (in_byte == CH_AT))
                    begin
                        d_delay = 1'b1;
                    end
                end
            end
            MODE_AMP:
            begin
                group_next  = in_byte;
                param_next  = '0;
                neg_next    = 1'b0;
                label_next  = '0;
                string_next = '0;
                mode_next   = MODE_AMPPAR;
            end
            MODE_AMPPAR:
            begin
                priority if (is_digit)
                begin
                    param_next = (param_mul > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                                 : param_mul[PARAM_W-1:0];
                end
                else if (in_byte == CH_MINUS)
                begin
                    neg_next = 1'b1;
                end
                else if ((in_byte == CH_PLUS) || (in_byte == CH_SPACE))
                begin
                    // blanks and plus signs carry nothing
                end
                else if (group_reg == CH_LO_D)
                begin
                    mode_next = MODE_TEXT;
                    if (console_reg)
                    begin
                        d_b0   = CH_ESC;
                        d_b1   = CH_LBRACKET;
                        d_b2   = CH_0;
                        d_fill = 2'd3;
                        d_sgr  = 1'b1;
                    end
                end
                else
                begin
                    if (group_reg == CH_LO_F)
                    begin
                        label_next  = label_upd;
                        string_next = string_upd;
                    end
                    param_next = '0;
                    neg_next   = 1'b0;
                    if (is_upper)
                    begin
                        if (group_reg == CH_LO_F)
                        begin
                            skip_next = skip_sum;
                            mode_next = (skip_sum != '0) ? MODE_SKIP : MODE_TEXT;
                        end
                        else
                        begin
                            skip_next = '0;
                            mode_next = MODE_TEXT;
                        end
                    end
                end
            end
            MODE_SKIP:
            begin
                if (skip_reg <= skip_t'(1))
                begin
                    skip_next = '0;
                    mode_next = MODE_TEXT;
                end
                else
                begin
                    skip_next = skip_reg - skip_t'(1);
                end
            end
            default:
            begin
                mode_next = MODE_TEXT;
                run_text  = 1'b1;
            end
        endcase

        if (run_text)
        begin
            if (in_byte == CH_ESC)
            begin
                mode_next = MODE_ESC;
            end
            else if (in_byte == CH_US)
            begin
                mode_next = MODE_US;
            end
        end

        // Append the text byte behind any underscore prefix.
        if (text_emit)
        begin
            unique case (d_fill)
                2'd0:    d_b0 = in_byte;
                2'd1:    d_b1 = in_byte;
                default: d_b2 = in_byte;
            endcase
            d_fill = d_fill + 2'd1;
        end
    end

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------
    // SGR attribute digits in order: blink, inverse, underline, half bright.
    always_comb
    begin
        priority if (mask_reg[0])
            sgr_byte = CH_5;
        else if (mask_reg[1])
            sgr_byte = CH_7;
        else if (mask_reg[2])
            sgr_byte = CH_4;
        else
            sgr_byte = CH_2;
    end

    assign out_valid = (cnt_reg != 2'd0) || delay_reg || sgr_reg;

    always_comb
    begin
        delay_request = 1'b0;
        priority if (cnt_reg != 2'd0)
        begin
            out_byte    = buf0_reg;
            last_of_run = (cnt_reg == 2'd1) && !sgr_reg;
        end
        else if (delay_reg)
        begin
            out_byte      = CH_NUL;
            delay_request = 1'b1;
            last_of_run   = 1'b1;
        end
        else if (sgr_reg && (mask_reg != 4'd0))
        begin
            out_byte    = half_reg ? sgr_byte : CH_SEMI;
            last_of_run = 1'b0;
        end
        else
        begin
            out_byte    = CH_LO_M;
            last_of_run = sgr_reg;
        end
    end

    assign out_xfer = out_valid && !out_stall;
    // Take a new byte once the current run is empty or its last result leaves.
    assign in_stall = out_valid && !(out_xfer && last_of_run);
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        buf2_next  = buf2_reg;
        cnt_next   = cnt_reg;
        delay_next = delay_reg;
        sgr_next   = sgr_reg;
        mask_next  = mask_reg;
        half_next  = half_reg;
        if (in_xfer)
        begin
            // load the run for the byte just taken (possibly empty)
            buf0_next  = d_b0;
            buf1_next  = d_b1;
            buf2_next  = d_b2;
            cnt_next   = d_fill;
            delay_next = d_delay;
            sgr_next   = d_sgr;
            mask_next  = in_byte[3:0];
            half_next  = 1'b0;
        end
        else if (out_xfer)
        begin
            priority if (cnt_reg != 2'd0)
            begin
                buf0_next = buf1_reg;
                buf1_next = buf2_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            else if (delay_reg)
            begin
                delay_next = 1'b0;
            end
            else if (mask_reg != 4'd0)
            begin
                if (half_reg)
                begin
                    mask_next = mask_reg & (mask_reg - 4'd1);
                    half_next = 1'b0;
                end
                else
                begin
                    half_next = 1'b1;
                end
            end
            else
            begin
                sgr_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            console_reg <= 1'b1;
            mode_reg    <= MODE_TEXT;
            group_reg   <= '0;
            param_reg   <= '0;
            neg_reg     <= 1'b0;
            label_reg   <= '0;
            string_reg  <= '0;
            skip_reg    <= '0;
            cnt_reg     <= 2'd0;
            delay_reg   <= 1'b0;
            sgr_reg     <= 1'b0;
            half_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                console_reg <= cfg_wr_data;
            end
            // advance the parser only on an input transfer
            if (in_xfer)
            begin
                mode_reg   <= mode_next;
                group_reg  <= group_next;
                param_reg  <= param_next;
                neg_reg    <= neg_next;
                label_reg  <= label_next;
                string_reg <= string_next;
                skip_reg   <= skip_next;
            end
            cnt_reg   <= cnt_next;
            delay_reg <= delay_next;
            sgr_reg   <= sgr_next;
            half_reg  <= half_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge clk)
    begin
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
        buf2_reg <= buf2_next;
        mask_reg <= mask_next;
    end

endmodule

// ===== hw/rtl/tet_checker.sv =====
`include "terminal_escape_translator_macros.svh"

module tet_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       delay_request,
    input logic       last_of_run
);
    import tet_pkg::*;

    // A delay request is a run of its own with a zero byte.
    `TET_ASSERT(a_delay_alone, clk, rst_n, !(out_valid && delay_request) || ((out_byte == CH_NUL) && last_of_run))
    // An emitted ESC always opens a sequence, never ends a run.
    `TET_ASSERT(a_esc_not_last, clk, rst_n, !(out_valid && !delay_request && (out_byte == CH_ESC)) || !last_of_run)
    // Input is held while results of the current byte remain.
    `TET_ASSERT(a_hold_input, clk, rst_n, !(out_valid && !last_of_run) || in_stall)
    // A stalled result stays offered.
    `TET_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte))

endmodule

bind terminal_escape_translator tet_checker u_tet_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .delay_request (delay_request),
    .last_of_run   (last_of_run)
);
